// ===== rtl/set_assoc_lru_cache_tags_core_assert.svh =====
// Assertion macros for the cache tag store core.
// Included by the top level; no other dependencies.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_CORE_ASSERT_SVH

// Property must hold on every clock edge outside reset.
`define SALC_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Property checked during reset as well.
`define SALC_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
// Shared types and constants for the cache tag store core.
// No dependencies.
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int AGE_WIDTH_DEF    = 32;
  localparam int ADDR_W           = 32;
  localparam int CNT_W            = 32;

  typedef enum logic [1:0] {
    OP_IFETCH = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STORE  = 2'd2,
    OP_MODIFY = 2'd3
  } op_t;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  // Work entry passed from front to back.
  typedef struct packed {
    logic [ADDR_W-1:0] tag;
    logic [11:0]       set;
    logic [4:0]        ways;
    logic              last;
  } lookup_t;

endpackage

// ===== rtl/salc_if.sv =====
// Valid/ready channel interface with generic payload.
// Depends on no package.
interface salc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/salc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/salc_front.sv =====
// Front end: accepts accesses, splits address, queues lookups.
// Depends on salc_pkg.
module salc_front import salc_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [2:0]        set_bits,
  input  logic [4:0]        block_bits,
  input  logic [3:0]        ways_in_use,
  output logic              q_valid,
  input  logic              q_pop,
  output lookup_t           q_head
);
  // two-entry queue
  lookup_t    q [2];
  logic [1:0] cnt;
  logic       rd;
  logic       pend;   // second lookup of a modify pending
  lookup_t    pend_e;
  lookup_t    pend_next;
  lookup_t    e;
  logic [5:0] sb, sh;
  logic [63:0] shifted;
  logic [4:0] wy;
  logic       push;
  logic [ADDR_W-1:0] tag;

  always_comb begin
    sb = (6'(set_bits) > 6'(MAX_SET_BITS)) ? 6'(MAX_SET_BITS) : 6'(set_bits);
    sh = sb + 6'(block_bits);
    shifted = {32'd0, in_address} >> sh;
    tag = shifted[31:0];
    wy = (ways_in_use == 4'd0) ? 5'd1 :
         (5'(ways_in_use) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(ways_in_use);
    e.tag  = tag;
    e.set  = 12'((({32'd0, in_address} >> block_bits) & ((64'd1 << sb) - 64'd1)));
    e.ways = wy;
    e.last = (in_op != OP_MODIFY);
    pend_next = e;
    pend_next.last = 1'b1;
  end

  assign in_ready = !pend && (cnt < 2'd2);
  logic acc;
  assign acc  = in_valid && in_ready;
  assign push = pend ? (cnt < 2'd2) : (acc && in_op != OP_IFETCH);
  assign q_valid = cnt != 2'd0;
  assign q_head  = q[rd];

  logic [0:0] wr;
  assign wr = rd ^ cnt[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; pend <= 1'b0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(q_pop);
      if (q_pop) rd <= ~rd;
      if (pend && push) pend <= 1'b0;
      else if (acc && in_op == OP_MODIFY) pend <= 1'b1;
    end
    if (push) q[wr] <= pend ? pend_e : e;
    if (acc) pend_e <= pend_next;
  end
endmodule

// ===== rtl/salc_back.sv =====
// Back end: per-set way lookup, LRU update, totals, output register.
// Depends on salc_pkg and salc_ram.
module salc_back import salc_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int AGE_WIDTH    = AGE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  lookup_t          q_head,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             o_hit,
  output logic             o_miss,
  output logic             o_evict,
  output logic             o_last,
  output logic [CNT_W-1:0] o_hits,
  output logic [CNT_W-1:0] o_misses,
  output logic [CNT_W-1:0] o_evicts,
  output logic             busy
);
  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int DEPTH = (NSETS > 1) ? NSETS : 2;
  localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WI    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LW    = 1 + ADDR_W + AGE_WIDTH;
  localparam int RW    = MAX_WAYS * LW;
  localparam logic [AGE_WIDTH-1:0] AMAX = '1;

  logic [MAX_WAYS-1:0]  vld;
  logic [ADDR_W-1:0]    tg [MAX_WAYS];
  logic [AGE_WIDTH-1:0] ag [MAX_WAYS];
  logic [RW-1:0]        rdata, wdata;
  logic                 we;
  logic [SW-1:0]        set_q;
  lookup_t              cur;
  logic                 phase;   // 1: row read data valid, compute and write
  logic [SW-1:0]        raddr;
  logic [SW-1:0]        waddr;
  logic                 clr;     // clearing pass over all set rows
  logic [SW-1:0]        clr_addr;

  assign raddr = SW'(q_head.set);
  assign waddr = clr ? clr_addr : set_q;
  assign busy  = phase;
  assign q_pop = q_valid && !phase && !clr && (!out_valid || out_ready);

  salc_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic hit, found_empty;
  logic [WI-1:0] hw, ew, lw, tw;
  logic [AGE_WIDTH-1:0] best;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      tg[w]  = rdata[w*LW +: ADDR_W];
      ag[w]  = rdata[w*LW+ADDR_W +: AGE_WIDTH];
      vld[w] = rdata[w*LW+ADDR_W+AGE_WIDTH];
    end
    hit = 1'b0; hw = '0; found_empty = 1'b0; ew = '0;
    lw = '0; best = ag[0];
    for (int w = MAX_WAYS-1; w >= 0; w--) begin
      if (5'(w) < cur.ways) begin
        if (vld[w] && tg[w] == cur.tag) begin hit = 1'b1; hw = WI'(w); end
        if (!vld[w]) begin found_empty = 1'b1; ew = WI'(w); end
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (5'(w) < cur.ways && ag[w] > best) begin best = ag[w]; lw = WI'(w); end
    end
    tw = hit ? hw : (found_empty ? ew : lw);
    wdata = rdata;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (5'(w) < cur.ways) begin
        if (WI'(w) == tw) begin
          wdata[w*LW+ADDR_W +: AGE_WIDTH] = '0;
          if (!hit) begin
            wdata[w*LW +: ADDR_W] = cur.tag;
            wdata[w*LW+ADDR_W+AGE_WIDTH] = 1'b1;
          end
        end else if (ag[w] != AMAX) begin
          wdata[w*LW+ADDR_W +: AGE_WIDTH] = ag[w] + 1'b1;
        end
      end
    end
    if (clr) wdata = '0;
    we = phase || clr;
  end

  function automatic logic [CNT_W-1:0] sat(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0; out_valid <= 1'b0;
      o_hits <= '0; o_misses <= '0; o_evicts <= '0;
      clr <= 1'b1; clr_addr <= '0;
    end else begin
      if (clr) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == SW'(NSETS-1)) clr <= 1'b0;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        phase <= 1'b1;
        cur   <= q_head;
        set_q <= raddr;
      end else if (phase) begin
        // advance: write row back and present result
        phase <= 1'b0;
        out_valid <= 1'b1;
        o_hit   <= hit;
        o_miss  <= !hit;
        o_evict <= !hit && !found_empty;
        o_last  <= cur.last;
        if (hit) o_hits <= sat(o_hits);
        else o_misses <= sat(o_misses);
        if (!hit && !found_empty) o_evicts <= sat(o_evicts);
      end
    end
  end
endmodule

// ===== rtl/set_assoc_lru_cache_tags_core.sv =====
// Set-associative cache tag store with LRU replacement: usage notes.
// Channels: acc (sink: op, address) and res (source: hit, miss, eviction,
// last and three running totals); configuration through an APB-style port
// with set_bits at 0x0, block_bits at 0x4, ways_in_use at 0x8.
// A load or store gives one result, a modify two (last marks the second),
// an instruction fetch none. A front stage splits the address and queues
// lookups in a two-entry queue; the back stage reads one set row from a RAM,
// then compares, picks the way and writes the row back.
// Each lookup occupies the back stage for a row read, then compare and
// write-back through the RAM write port; no new lookup starts before the
// last is through. A result passes the queue, row read and output register.
// Reset clears totals and the queue at once; then a clearing pass over all
// 1 << MAX_SET_BITS set rows (64 by default) zeroes each row (valid bits,
// tags, ages), and no lookup starts before it ends; accesses may queue.
// A stalled result register holds the back stage; the queue then fills and
// acc.ready drops.
module set_assoc_lru_cache_tags_core import salc_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int AGE_WIDTH    = AGE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  salc_if.sink        acc,
  salc_if.source      res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "set_assoc_lru_cache_tags_core_assert.svh"

  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_in_use;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= SET_BITS_RST; block_bits <= BLOCK_BITS_RST; ways_in_use <= WAYS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SET_BITS:   set_bits    <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits  <= pwdata[4:0];
        REG_WAYS:       ways_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:   prdata = {29'd0, set_bits};
      REG_BLOCK_BITS: prdata = {27'd0, block_bits};
      REG_WAYS:       prdata = {28'd0, ways_in_use};
      default:        prdata = '0;
    endcase
  end

  logic    q_valid, q_pop, busy;
  lookup_t q_head;

  salc_front #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_front (
    .clk, .rst, .in_valid(acc.valid), .in_ready(acc.ready),
    .in_op(acc.data.op), .in_address(acc.data.address),
    .set_bits, .block_bits, .ways_in_use,
    .q_valid, .q_pop, .q_head
  );

  salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
              .AGE_WIDTH(AGE_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head,
    .out_valid(res.valid), .out_ready(res.ready),
    .o_hit(res.data.hit), .o_miss(res.data.miss), .o_evict(res.data.eviction),
    .o_last(res.data.last), .o_hits(res.data.hits_so_far),
    .o_misses(res.data.misses_so_far), .o_evicts(res.data.evictions_so_far),
    .busy
  );

  `SALC_ASSERT(a_hit_xor_miss, clk, rst, res.valid |-> (res.data.hit != res.data.miss), "hit and miss both or neither")
  `SALC_ASSERT(a_evict_needs_miss, clk, rst, (res.valid && res.data.eviction) |-> res.data.miss, "eviction without miss")
  `SALC_ASSERT(a_pop_idle, clk, rst, q_pop |-> !busy, "queue popped while back stage busy")
  `SALC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !res.valid, "result valid after reset")
endmodule

// ===== tb/tb_set_assoc_lru_cache_tags_core.sv =====
// Testbench for the set-associative LRU cache tag store core.
// Drives accesses, predicts every result with its own tag store model and checks it.
// Depends on salc_pkg, salc_if and set_assoc_lru_cache_tags_core.
`timescale 1ns / 100ps

module tb_set_assoc_lru_cache_tags_core;
  import salc_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [31:0] address;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic        miss;
    logic        eviction;
    logic        last;
    logic [31:0] hits_so_far;
    logic [31:0] misses_so_far;
    logic [31:0] evictions_so_far;
  } outcome_t;

  localparam int NSETS = 1 << MAX_SET_BITS_DEF;
  localparam int NLINES = NSETS * MAX_WAYS_DEF;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  salc_if #(.payload_t(access_t))  acc_ch ();
  salc_if #(.payload_t(outcome_t)) res_ch ();

  set_assoc_lru_cache_tags_core DUT (
    .clk(clk), .rst(rst), .acc(acc_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow tag store and registers.
  logic        sh_valid [NLINES];
  logic [31:0] sh_tag   [NLINES];
  logic [31:0] sh_age   [NLINES];
  logic [31:0] sh_hits, sh_misses, sh_evicts;
  logic [2:0]  cfg_set_bits;
  logic [4:0]  cfg_block_bits;
  logic [3:0]  cfg_ways;

  access_t  pending_acc[$];
  outcome_t expected_out[$];
  int       errors;
  int       accepted;
  int       gap_left;
  int       stall_left;
  bit       no_idle;
  bit       hold_res;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 500000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic do_lookup(logic [31:0] addr, logic is_last);
    int sb, ways, base, target;
    logic [63:0] a64;
    logic [31:0] tag, best;
    logic hit, evict;
    outcome_t o;
    sb = (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cfg_set_bits;
    ways = (cfg_ways < 1) ? 1 : (cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cfg_ways;
    a64 = {32'd0, addr};
    tag = 32'(a64 >> (sb + cfg_block_bits));
    base = int'((a64 >> cfg_block_bits) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS_DEF;
    hit = 1'b0;
    evict = 1'b0;
    target = ways;
    for (int w = 0; w < ways; w++) begin
      if (!hit && sh_valid[base + w] && sh_tag[base + w] == tag) begin
        hit = 1'b1;
        target = w;
      end
    end
    if (hit) begin
      sh_hits = sat_inc(sh_hits);
    end else begin
      sh_misses = sat_inc(sh_misses);
      for (int w = ways - 1; w >= 0; w--)
        if (!sh_valid[base + w]) target = w;
      if (target == ways) begin
        // Full set: replace the oldest way, lowest index on ties.
        evict = 1'b1;
        sh_evicts = sat_inc(sh_evicts);
        target = 0;
        best = sh_age[base];
        for (int w = 1; w < ways; w++) begin
          if (sh_age[base + w] > best) begin
            best = sh_age[base + w];
            target = w;
          end
        end
      end
      sh_tag[base + target] = tag;
      sh_valid[base + target] = 1'b1;
    end
    for (int w = 0; w < ways; w++)
      sh_age[base + w] = sat_inc(sh_age[base + w]);
    sh_age[base + target] = 32'd0;
    o.hit = hit;
    o.miss = !hit;
    o.eviction = evict;
    o.last = is_last;
    o.hits_so_far = sh_hits;
    o.misses_so_far = sh_misses;
    o.evictions_so_far = sh_evicts;
    expected_out.push_back(o);
  endtask

  task automatic predict_access(access_t a);
    if (a.op == OP_MODIFY) begin
      do_lookup(a.address, 1'b0);
      do_lookup(a.address, 1'b1);
    end else if (a.op != OP_IFETCH) begin
      do_lookup(a.address, 1'b1);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // Driver: offer pending accesses with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      acc_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (acc_ch.valid && acc_ch.ready) begin
        predict_access(acc_ch.data);
        accepted++;
      end
      if (!acc_ch.valid || acc_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          acc_ch.valid <= 1'b0;
        end else if (pending_acc.size() > 0) begin
          acc_ch.data <= pending_acc.pop_front();
          acc_ch.valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          acc_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and result checks.
  always @(posedge clk) begin
    outcome_t w;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_out.size() == 0) begin
          report("unexpected result", 32'd0, 32'd0);
        end else begin
          w = expected_out.pop_front();
          if (res_ch.data.hit != w.hit) report("hit", res_ch.data.hit, w.hit);
          if (res_ch.data.miss != w.miss) report("miss", res_ch.data.miss, w.miss);
          if (res_ch.data.eviction != w.eviction)
            report("eviction", res_ch.data.eviction, w.eviction);
          if (res_ch.data.last != w.last) report("last", res_ch.data.last, w.last);
          if (res_ch.data.hits_so_far != w.hits_so_far)
            report("hits_so_far", res_ch.data.hits_so_far, w.hits_so_far);
          if (res_ch.data.misses_so_far != w.misses_so_far)
            report("misses_so_far", res_ch.data.misses_so_far, w.misses_so_far);
          if (res_ch.data.evictions_so_far != w.evictions_so_far)
            report("evictions_so_far", res_ch.data.evictions_so_far, w.evictions_so_far);
        end
      end
      if (hold_res) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Long receiver hold-off so the input queue fills and stalls.
  initial begin
    hold_res = 1'b0;
    wait (accepted >= 300);
    @(posedge clk);
    hold_res = 1'b1;
    repeat (300) @(posedge clk);
    hold_res = 1'b0;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SET_BITS:   cfg_set_bits = v[2:0];
      REG_BLOCK_BITS: cfg_block_bits = v[4:0];
      REG_WAYS:       cfg_ways = v[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_acc.size() > 0 || acc_ch.valid || expected_out.size() > 0)
      @(posedge clk);
    // an instruction fetch leaves nothing to wait on; let the pipe settle
    repeat (20) @(posedge clk);
  endtask

  task automatic push_acc(op_t op, logic [31:0] addr);
    access_t a;
    a.op = op;
    a.address = addr;
    pending_acc.push_back(a);
  endtask

  task automatic fill_phase(int count);
    logic [31:0] pool [24];
    logic [63:0] v;
    int sb, span;
    sb = (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cfg_set_bits;
    span = cfg_ways + 3;
    for (int j = 0; j < 24; j++) begin
      v = (64'($urandom_range(0, span)) << (sb + cfg_block_bits))
        | (64'($urandom_range(0, 3)) << cfg_block_bits)
        | (64'($urandom) & ((64'd1 << cfg_block_bits) - 64'd1));
      pool[j] = v[31:0];
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15)
        push_acc(op_t'($urandom_range(0, 3)), $urandom);
      else
        push_acc(op_t'($urandom_range(0, 3)), pool[$urandom_range(0, 23)]);
    end
  endtask

  initial begin
    int cfgs [8][3];
    cfgs = '{'{2, 4, 4}, '{0, 0, 8}, '{6, 26, 8}, '{7, 31, 15},
             '{3, 5, 0}, '{6, 2, 2}, '{1, 29, 3}, '{4, 4, 8}};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    acc_ch.valid = 1'b0;
    acc_ch.data = '0;
    res_ch.ready = 1'b0;
    errors = 0;
    accepted = 0;
    no_idle = 1'b0;
    for (int i = 0; i < NLINES; i++) begin
      sh_valid[i] = 1'b0;
      sh_tag[i] = '0;
      sh_age[i] = '0;
    end
    sh_hits = '0;
    sh_misses = '0;
    sh_evicts = '0;
    cfg_set_bits = SET_BITS_RST;
    cfg_block_bits = BLOCK_BITS_RST;
    cfg_ways = WAYS_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, every op, extremes, hit after fill, eviction.
    push_acc(OP_IFETCH, 32'h0000_0000);
    push_acc(OP_LOAD, 32'h0000_0000);
    push_acc(OP_LOAD, 32'h0000_0004);
    push_acc(OP_STORE, 32'hFFFF_FFFF);
    push_acc(OP_MODIFY, 32'hFFFF_FFF0);
    push_acc(OP_LOAD, 32'h0000_1000);
    push_acc(OP_MODIFY, 32'h0000_0000);
    push_acc(OP_IFETCH, 32'hFFFF_FFFF);
    push_acc(OP_STORE, 32'hAAAA_5555);
    push_acc(OP_LOAD, 32'h5555_AAAA);
    push_acc(OP_MODIFY, 32'h5555_AAAA);
    push_acc(OP_LOAD, 32'h0000_0010);
    drain();

    for (int p = 0; p < 8; p++) begin
      reg_write(REG_SET_BITS, cfgs[p][0]);
      reg_write(REG_BLOCK_BITS, cfgs[p][1]);
      reg_write(REG_WAYS, cfgs[p][2]);
      no_idle = (p % 3 == 2);
      fill_phase(160);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_if.sv
rtl/salc_ram.sv
rtl/salc_front.sv
rtl/salc_back.sv
rtl/set_assoc_lru_cache_tags_core.sv
tb/tb_set_assoc_lru_cache_tags_core.sv
